@@ rtl/bme_pkg.sv @@
// Shared types and constants for the binary mask erosion block.
package bme_pkg;

    localparam int ROW_W    = 64;
    localparam int WIDTH_W  = 7;
    localparam int PASSES_W = 4;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic REG_ROW_WIDTH = 1'b0;
    localparam logic REG_PASSES    = 1'b1;

    localparam logic [WIDTH_W-1:0]  RST_ROW_WIDTH = 7'd64;
    localparam logic [PASSES_W-1:0] RST_PASSES    = 4'd1;

    typedef struct packed {
        logic [ROW_W-1:0] bits;
        logic             last;
    } t_row;

endpackage

@@ rtl/bme_lane.sv @@
// One column lane: 3x3 AND over the neighborhood of a single pixel.
module bme_lane (
    input  logic [2:0] i_above,
    input  logic [2:0] i_mid,
    input  logic [2:0] i_below,
    input  logic       i_en,
    output logic       o_bit
);

    assign o_bit = (&i_above) & (&i_mid) & (&i_below) & i_en;

endmodule

@@ rtl/bme_stage.sv @@
// One erosion pass: two line registers, column lanes and an output register.
module bme_stage
    import bme_pkg::*;
#(
    parameter int MAX_WIDTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clear,
    input  logic [MAX_WIDTH-1:0] i_mask,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_row                 i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_row                 o_out
);

    logic [MAX_WIDTH-1:0] r_prev;
    logic [MAX_WIDTH-1:0] r_cur;
    logic                 r_held;
    logic                 r_pend;
    logic                 r_out_valid;
    t_row                 r_out;

    logic [MAX_WIDTH-1:0] x;
    logic [MAX_WIDTH+1:0] pad_above;
    logic [MAX_WIDTH+1:0] pad_mid;
    logic [MAX_WIDTH+1:0] pad_below;
    logic [MAX_WIDTH-1:0] eroded;
    logic                 out_free;
    logic                 accept;

    assign x         = i_in.bits[MAX_WIDTH-1:0];
    assign pad_above = {1'b0, r_prev, 1'b0};
    assign pad_mid   = {1'b0, r_cur, 1'b0};
    assign pad_below = {1'b0, x, 1'b0};

    for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_lane
        bme_lane u_lane (
            .i_above (pad_above[c+2:c]),
            .i_mid   (pad_mid[c+2:c]),
            .i_below (pad_below[c+2:c]),
            .i_en    (i_mask[c]),
            .o_bit   (eroded[c])
        );
    end

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_pend && out_free;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_held      <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (accept) begin
            if (!r_held) begin
                if (i_in.last) begin
                    // single-row frame: always empty
                    r_out_valid <= 1'b1;
                    r_out.bits  <= '0;
                    r_out.last  <= 1'b1;
                end else begin
                    r_out_valid <= 1'b0;
                    r_prev      <= '0;
                    r_cur       <= x;
                    r_held      <= 1'b1;
                end
            end else begin
                r_out_valid <= 1'b1;
                r_out.bits  <= ROW_W'(eroded);
                r_out.last  <= 1'b0;
                if (i_in.last) begin
                    // bottom row erodes against background: empty, sent next
                    r_pend <= 1'b1;
                    r_held <= 1'b0;
                end else begin
                    r_prev <= r_cur;
                    r_cur  <= x;
                end
            end
        end else if (r_pend && out_free) begin
            r_out_valid <= 1'b1;
            r_out.bits  <= '0;
            r_out.last  <= 1'b1;
            r_pend      <= 1'b0;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

@@ rtl/binary_mask_erosion.sv @@
// Repeated 3x3 binary erosion of a row-streamed mask; one mask row per item on
// the input and output streams. The block takes one row per clock cycle when
// the output is not stalled and no flush row is pending. Each configured pass
// is one line-buffered stage that delays the stream by one row; a row marked
// last flushes the chain and yields up to passes+1 rows, each stage sending
// its final empty row via its single output register. With passes at zero
// each row passes through, masked to row_width, after one register.
// Registers: row_width at 0x0 (bits outside the width read as background and
// come out clear), passes at 0x4 (values above MAX_PASSES act as MAX_PASSES).
// Writing passes drops any frame in progress; write either only while idle.
module binary_mask_erosion
    import bme_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_PASSES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [ROW_W-1:0]  s_axis_tdata,  // row_bits[63:0]
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [ROW_W-1:0]  m_axis_tdata,  // eroded_bits[63:0]
    output logic              m_axis_tlast,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int PW = $clog2(MAX_PASSES + 1);

    logic [WIDTH_W-1:0]  r_row_width;
    logic [PASSES_W-1:0] r_passes;
    logic                r_m_valid;
    t_row                r_m;

    logic                 cfg_wr;
    logic                 clear;
    logic [PW-1:0]        np;
    logic [MAX_WIDTH-1:0] mask;
    t_row                 in_row;
    logic                 m_ready;
    logic                 m_in_valid;
    t_row                 m_in;

    logic st_in_valid  [MAX_PASSES];
    logic st_in_ready  [MAX_PASSES];
    logic st_out_valid [MAX_PASSES];
    logic st_out_ready [MAX_PASSES];
    t_row st_in        [MAX_PASSES];
    t_row st_out       [MAX_PASSES];

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign clear  = cfg_wr && (paddr[2] == REG_PASSES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= RST_ROW_WIDTH;
            r_passes    <= RST_PASSES;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_ROW_WIDTH: r_row_width <= pwdata[WIDTH_W-1:0];
                REG_PASSES:    r_passes    <= pwdata[PASSES_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ROW_WIDTH: prdata = DATA_W'(r_row_width);
            REG_PASSES:    prdata = DATA_W'(r_passes);
            default:       prdata = '0;
        endcase
    end

    assign np = (int'(r_passes) > MAX_PASSES) ? PW'(MAX_PASSES) : PW'(r_passes);

    for (genvar c = 0; c < MAX_WIDTH; c++) begin : g_mask
        assign mask[c] = r_row_width > WIDTH_W'(c);
    end

    assign in_row.bits = ROW_W'(s_axis_tdata[MAX_WIDTH-1:0] & mask);
    assign in_row.last = s_axis_tlast;

    // stage chain
    for (genvar s = 0; s < MAX_PASSES; s++) begin : g_stage
        if (s == 0) begin : g_first
            assign st_in_valid[s] = s_axis_tvalid && (np != '0);
            assign st_in[s]       = in_row;
        end else begin : g_next
            assign st_in_valid[s] = st_out_valid[s-1] && (PW'(s) < np);
            assign st_in[s]       = st_out[s-1];
        end

        if (s == MAX_PASSES - 1) begin : g_tail
            assign st_out_ready[s] = (PW'(s + 1) == np) && m_ready;
        end else begin : g_mid
            assign st_out_ready[s] = (PW'(s + 1) == np) ? m_ready : st_in_ready[s+1];
        end

        bme_stage #(
            .MAX_WIDTH (MAX_WIDTH)
        ) u_stage (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_clear     (clear),
            .i_mask      (mask),
            .i_in_valid  (st_in_valid[s]),
            .o_in_ready  (st_in_ready[s]),
            .i_in        (st_in[s]),
            .o_out_valid (st_out_valid[s]),
            .i_out_ready (st_out_ready[s]),
            .o_out       (st_out[s])
        );
    end

    assign s_axis_tready = (np == '0) ? m_ready : st_in_ready[0];

    // merge: pick the last active stage, or the bypass path
    always_comb begin
        m_in_valid = s_axis_tvalid;
        m_in       = in_row;
        for (int s = 0; s < MAX_PASSES; s++) begin
            if (PW'(s + 1) == np) begin
                m_in_valid = st_out_valid[s];
                m_in       = st_out[s];
            end
        end
    end

    assign m_ready = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (m_ready) begin
            r_m_valid <= m_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_ready && m_in_valid) begin
            r_m <= m_in;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m.bits;
    assign m_axis_tlast  = r_m.last;

endmodule

@@ rtl/bme_checker.sv @@
// Port-level checks for the binary mask erosion block, bound to the top level.
module bme_checker
    import bme_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [ROW_W-1:0]  m_axis_tdata,
    input logic              m_axis_tlast,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [ADDR_W-1:0] paddr,
    input logic [DATA_W-1:0] pwdata,
    input logic [DATA_W-1:0] prdata,
    input logic              pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    a_no_out_after_reset: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_width_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(psel && penable && pwrite && pready
            && (paddr[2] == REG_ROW_WIDTH))
        && (paddr[2] == REG_ROW_WIDTH)
        |-> prdata[WIDTH_W-1:0] == $past(pwdata[WIDTH_W-1:0]))
        else $error("row_width readback mismatch");

    a_prdata_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (paddr[2] == REG_ROW_WIDTH) |-> prdata[DATA_W-1:WIDTH_W] == '0)
        else $error("row_width readback has stray upper bits");

endmodule

bind binary_mask_erosion bme_checker u_bme_checker (.*);
